/* hdl/assert_macros.svh */
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising edge outside reset
`define CGVF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CGVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CGVF_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define CGVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* hdl/cgvf_pkg.sv */
// shared types, constants and helpers of the guidance velocity field
`timescale 1ns / 1ps

package cgvf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 25;

  localparam int POS_W    = 25;
  localparam int VEL_W    = 21;
  localparam int RADIUS_W = 24;
  localparam int HEIGHT_W = 25;
  localparam int RSQ_W    = 25;
  localparam int GAIN_W   = 24;
  localparam int SPEED_W  = 20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TUBE_RADIUS        = 3'd0,
    REG_TUBE_CENTER_HEIGHT = 3'd1,
    REG_SECOND_RADIUS_SQ   = 3'd2,
    REG_GAIN_FIRST         = 3'd3,
    REG_GAIN_SECOND        = 3'd4,
    REG_HEIGHT_OFFSET      = 3'd5,
    REG_SPEED              = 3'd6
  } cfg_reg_t;

  localparam logic [RADIUS_W-1:0]        TUBE_RADIUS_RST        = 24'd65536;
  localparam logic signed [HEIGHT_W-1:0] TUBE_CENTER_HEIGHT_RST = 25'sd98304;
  localparam logic [RSQ_W-1:0]           SECOND_RADIUS_SQ_RST   = 25'd262144;
  localparam logic [GAIN_W-1:0]          GAIN_FIRST_RST         = 24'd65536;
  localparam logic [GAIN_W-1:0]          GAIN_SECOND_RST        = 24'd65536;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_OFFSET_RST      = 25'sd327680;
  localparam logic [SPEED_W-1:0]         SPEED_RST              = 20'd32768;

  typedef logic signed [71:0] wide_t;

  // advance and valid of the beat entering a pipelined unit
  typedef struct packed {
    logic advance;
    logic valid;
  } stage_ctl_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input wide_t v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/cgvf_sqrt.sv */
// pipelined integer square root, STEPS root bits per stage, LANES lanes
`timescale 1ns / 1ps

module cgvf_sqrt #(
  parameter int RAD_W  = 48,
  parameter int LANES  = 1,
  parameter int SIDE_W = 8,
  parameter int STEPS  = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cgvf_pkg::stage_ctl_t                 ctl,
  input  logic [LANES-1:0][RAD_W-1:0]          rad,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  output logic [LANES-1:0][RAD_W/2-1:0]        root,
  output logic [SIDE_W-1:0]                    side_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int NSTAGE = (ROOT_W + STEPS - 1) / STEPS;

  logic [LANES-1:0][RAD_W-1:0]  rem_q  [NSTAGE];
  logic [LANES-1:0][ROOT_W-1:0] root_q [NSTAGE];
  logic [SIDE_W-1:0]            side_q [NSTAGE];
  logic                         vld_q  [NSTAGE];

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    logic [LANES-1:0][RAD_W-1:0]  rem_in;
    logic [LANES-1:0][RAD_W-1:0]  rem_next;
    logic [LANES-1:0][ROOT_W-1:0] root_in;
    logic [LANES-1:0][ROOT_W-1:0] root_next;
    logic [SIDE_W-1:0]            side_stage;
    logic                         vld_in;

    if (s == 0) begin : g_first
      assign rem_in     = rad;
      assign root_in    = '0;
      assign side_stage = side_in;
      assign vld_in     = ctl.valid;
    end else begin : g_rest
      assign rem_in     = rem_q[s-1];
      assign root_in    = root_q[s-1];
      assign side_stage = side_q[s-1];
      assign vld_in     = vld_q[s-1];
    end

    // remainder method: try root bit i against rem = n - q^2
    always_comb begin
      logic [RAD_W-1:0] trial;
      int bit_i;
      rem_next  = rem_in;
      root_next = root_in;
      trial     = '0;
      bit_i     = 0;
      for (int k = 0; k < LANES; k++) begin
        for (int j = 0; j < STEPS; j++) begin
          bit_i = ROOT_W - 1 - (s * STEPS + j);
          if (bit_i >= 0) begin
            trial = (RAD_W'(root_next[k]) << (bit_i + 1)) | (RAD_W'(1) << (2 * bit_i));
            if (rem_next[k] >= trial) begin
              rem_next[k]  = rem_next[k] - trial;
              root_next[k] = root_next[k] | (ROOT_W'(1) << bit_i);
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rem_q[s]  <= rem_next;
        root_q[s] <= root_next;
        side_q[s] <= side_stage;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (ctl.advance) begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign out_valid = vld_q[NSTAGE-1];
  assign root      = root_q[NSTAGE-1];
  assign side_out  = side_q[NSTAGE-1];

endmodule

/* hdl/cgvf_div.sv */
// pipelined restoring divider, lanes share one divisor
`timescale 1ns / 1ps

module cgvf_div #(
  parameter int NUM_W  = 52,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 20,
  parameter int LANES  = 3,
  parameter int SIDE_W = 4,
  parameter int STEPS  = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cgvf_pkg::stage_ctl_t          ctl,
  input  logic [LANES-1:0][NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]              den,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  output logic [LANES-1:0][QUO_W-1:0]   quo,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int NSTAGE = (QUO_W + STEPS - 1) / STEPS;
  localparam int CMP_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [LANES-1:0][NUM_W-1:0] rem_q  [NSTAGE];
  logic [LANES-1:0][QUO_W-1:0] quo_q  [NSTAGE];
  logic [DEN_W-1:0]            den_q  [NSTAGE];
  logic [SIDE_W-1:0]           side_q [NSTAGE];
  logic                        vld_q  [NSTAGE];

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    logic [LANES-1:0][NUM_W-1:0] rem_in;
    logic [LANES-1:0][NUM_W-1:0] rem_next;
    logic [LANES-1:0][QUO_W-1:0] quo_in;
    logic [LANES-1:0][QUO_W-1:0] quo_next;
    logic [DEN_W-1:0]            den_in;
    logic [SIDE_W-1:0]           side_stage;
    logic                        vld_in;

    if (s == 0) begin : g_first
      assign rem_in     = num;
      assign quo_in     = '0;
      assign den_in     = den;
      assign side_stage = side_in;
      assign vld_in     = ctl.valid;
    end else begin : g_rest
      assign rem_in     = rem_q[s-1];
      assign quo_in     = quo_q[s-1];
      assign den_in     = den_q[s-1];
      assign side_stage = side_q[s-1];
      assign vld_in     = vld_q[s-1];
    end

    always_comb begin
      logic [CMP_W-1:0] trial;
      int bit_i;
      rem_next = rem_in;
      quo_next = quo_in;
      trial    = '0;
      bit_i    = 0;
      for (int k = 0; k < LANES; k++) begin
        for (int j = 0; j < STEPS; j++) begin
          bit_i = QUO_W - 1 - (s * STEPS + j);
          if (bit_i >= 0) begin
            trial = CMP_W'(den_in) << bit_i;
            if (CMP_W'(rem_next[k]) >= trial) begin
              rem_next[k] = NUM_W'(CMP_W'(rem_next[k]) - trial);
              quo_next[k] = quo_next[k] | (QUO_W'(1) << bit_i);
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        rem_q[s]  <= rem_next;
        quo_q[s]  <= quo_next;
        den_q[s]  <= den_in;
        side_q[s] <= side_stage;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (ctl.advance) begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign out_valid = vld_q[NSTAGE-1];
  assign quo       = quo_q[NSTAGE-1];
  assign side_out  = side_q[NSTAGE-1];

endmodule

/* hdl/curve_guidance_velocity_field.sv */
// top level of the guidance velocity field towards a two-cylinder curve
//
//   channel  handshake              payload
//   in       in_valid / in_stall    pos_x, pos_y, pos_z
//   out      out_valid / out_stall  vel_x, vel_y, vel_z, zero_field
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat enters every cycle while in_stall is low
// one stall freezes every stage at once, so no beat is dropped or doubled
// rst is synchronous: valid bits clear, configuration registers return to their defaults
// cfg_ready is always high; writes are meant for an idle pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"

module curve_guidance_velocity_field #(
  parameter int FRAC_BITS = cgvf_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [cgvf_pkg::POS_W-1:0]     pos_x,
  input  logic signed [cgvf_pkg::POS_W-1:0]     pos_y,
  input  logic signed [cgvf_pkg::POS_W-1:0]     pos_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cgvf_pkg::VEL_W-1:0]     vel_x,
  output logic signed [cgvf_pkg::VEL_W-1:0]     vel_y,
  output logic signed [cgvf_pkg::VEL_W-1:0]     vel_z,
  output logic                                  zero_field,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cgvf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [cgvf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // radicand of the error root is |e| << FRAC_BITS, kept at even width
  localparam int RAD1_W  = 32 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int ROOT1_W = RAD1_W / 2;
  localparam int SIG_W   = ROOT1_W + 1;
  localparam int NORM_RAD_W = 64;
  localparam int NORM_W  = NORM_RAD_W / 2;
  localparam int NUM_W   = 32 + cgvf_pkg::SPEED_W;
  localparam int QUO_W   = cgvf_pkg::SPEED_W;
  localparam int SIDE1_W = 2 + 3 * 32 + 26 + 28 + 26 + 27;
  localparam int SIDE2_W = 4 + 3 * NUM_W;
  localparam int SIDE3_W = 4;

  // configuration registers
  logic [cgvf_pkg::RADIUS_W-1:0]        tube_radius;
  logic signed [cgvf_pkg::HEIGHT_W-1:0] tube_center_height;
  logic [cgvf_pkg::RSQ_W-1:0]           second_radius_sq;
  logic [cgvf_pkg::GAIN_W-1:0]          gain_first;
  logic [cgvf_pkg::GAIN_W-1:0]          gain_second;
  logic signed [cgvf_pkg::HEIGHT_W-1:0] height_offset;
  logic [cgvf_pkg::SPEED_W-1:0]         speed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tube_radius        <= cgvf_pkg::TUBE_RADIUS_RST;
      tube_center_height <= cgvf_pkg::TUBE_CENTER_HEIGHT_RST;
      second_radius_sq   <= cgvf_pkg::SECOND_RADIUS_SQ_RST;
      gain_first         <= cgvf_pkg::GAIN_FIRST_RST;
      gain_second        <= cgvf_pkg::GAIN_SECOND_RST;
      height_offset      <= cgvf_pkg::HEIGHT_OFFSET_RST;
      speed              <= cgvf_pkg::SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cgvf_pkg::cfg_reg_t'(cfg_index))
        cgvf_pkg::REG_TUBE_RADIUS: begin
          tube_radius <= cfg_data[cgvf_pkg::RADIUS_W-1:0];
        end
        cgvf_pkg::REG_TUBE_CENTER_HEIGHT: begin
          tube_center_height <= cfg_data[cgvf_pkg::HEIGHT_W-1:0];
        end
        cgvf_pkg::REG_SECOND_RADIUS_SQ: begin
          second_radius_sq <= cfg_data[cgvf_pkg::RSQ_W-1:0];
        end
        cgvf_pkg::REG_GAIN_FIRST: begin
          gain_first <= cfg_data[cgvf_pkg::GAIN_W-1:0];
        end
        cgvf_pkg::REG_GAIN_SECOND: begin
          gain_second <= cfg_data[cgvf_pkg::GAIN_W-1:0];
        end
        cgvf_pkg::REG_HEIGHT_OFFSET: begin
          height_offset <= cfg_data[cgvf_pkg::HEIGHT_W-1:0];
        end
        cgvf_pkg::REG_SPEED: begin
          speed <= cfg_data[cgvf_pkg::SPEED_W-1:0];
        end
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // whole pipeline moves together unless the output beat is held
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  // stage 1: shift z by the offset, d relative to the first axis
  logic signed [25:0] z_in;
  logic signed [26:0] d_in;
  logic               v1;
  logic signed [24:0] x1, y1;
  logic signed [25:0] z1;
  logic signed [26:0] d1;

  always_comb begin
    z_in = 26'(pos_z) - 26'(height_offset);
    d_in = 27'(z_in) - 27'(tube_center_height);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x1 <= pos_x;
      y1 <= pos_y;
      z1 <= z_in;
      d1 <= d_in;
    end
  end

  // stage 2: gradients, squares and cross-product terms
  logic signed [25:0] n1x_c, n2y_c;
  logic signed [27:0] n1z_c;
  logic signed [26:0] n2z_c;
  logic signed [24:0] tr_s;
  logic signed [49:0] xx_p, yy_p, rr_p;
  logic signed [53:0] dd_p, pcx_p;
  logic signed [51:0] zz_p, pcz_p;
  logic signed [52:0] pcy_p;

  logic               v2;
  logic signed [31:0] xx2, dd2, yy2, zz2, rr2, qcx2, qcy2, cz2;
  logic signed [25:0] n1x2, n2y2;
  logic signed [27:0] n1z2;
  logic signed [26:0] n2z2;

  always_comb begin
    n1x_c = {x1, 1'b0};
    n2y_c = {y1, 1'b0};
    n1z_c = {d1, 1'b0};
    n2z_c = {z1, 1'b0};
    tr_s  = $signed({1'b0, tube_radius});
    xx_p  = x1 * x1;
    yy_p  = y1 * y1;
    dd_p  = d1 * d1;
    zz_p  = z1 * z1;
    rr_p  = tr_s * tr_s;
    pcx_p = n1z_c * n2y_c;
    pcy_p = n1x_c * n2z_c;
    pcz_p = n1x_c * n2y_c;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      xx2  <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(xx_p >>> FRAC_BITS));
      yy2  <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(yy_p >>> FRAC_BITS));
      dd2  <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(dd_p >>> FRAC_BITS));
      zz2  <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(zz_p >>> FRAC_BITS));
      rr2  <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(rr_p >>> FRAC_BITS));
      qcx2 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(pcx_p >>> FRAC_BITS));
      qcy2 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(pcy_p >>> FRAC_BITS));
      cz2  <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(pcz_p >>> FRAC_BITS));
      n1x2 <= n1x_c;
      n2y2 <= n2y_c;
      n1z2 <= n1z_c;
      n2z2 <= n2z_c;
    end
  end

  // stage 3: surface errors, their magnitudes as root radicands, sign of cross terms
  logic signed [31:0] e1_c, e2_c, cx_c, cy_c;
  logic [31:0]        mag1_c, mag2_c;

  logic               v3;
  logic [RAD1_W-1:0]  rad1_3, rad2_3;
  logic               neg1_3, neg2_3;
  logic signed [31:0] cx3, cy3, cz3;
  logic signed [25:0] n1x3, n2y3;
  logic signed [27:0] n1z3;
  logic signed [26:0] n2z3;

  always_comb begin
    e1_c = cgvf_pkg::sat32(cgvf_pkg::wide_t'(xx2) + cgvf_pkg::wide_t'(dd2)
                           - cgvf_pkg::wide_t'(rr2));
    e2_c = cgvf_pkg::sat32(cgvf_pkg::wide_t'(yy2) + cgvf_pkg::wide_t'(zz2)
                           - cgvf_pkg::wide_t'($signed({1'b0, second_radius_sq})));
    cx_c = cgvf_pkg::sat32(-cgvf_pkg::wide_t'(qcx2));
    cy_c = cgvf_pkg::sat32(-cgvf_pkg::wide_t'(qcy2));
    mag1_c = e1_c[31] ? 32'(-cgvf_pkg::wide_t'(e1_c)) : 32'(e1_c);
    mag2_c = e2_c[31] ? 32'(-cgvf_pkg::wide_t'(e2_c)) : 32'(e2_c);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rad1_3 <= RAD1_W'({mag1_c, {FRAC_BITS{1'b0}}});
      rad2_3 <= RAD1_W'({mag2_c, {FRAC_BITS{1'b0}}});
      neg1_3 <= e1_c[31];
      neg2_3 <= e2_c[31];
      cx3    <= cx_c;
      cy3    <= cy_c;
      cz3    <= cz2;
      n1x3   <= n1x2;
      n2y3   <= n2y2;
      n1z3   <= n1z2;
      n2z3   <= n2z2;
    end
  end

  // signed square roots of both errors
  cgvf_pkg::stage_ctl_t        ctl_err;
  logic                        v_err;
  logic [1:0][ROOT1_W-1:0]     err_root;
  logic [SIDE1_W-1:0]          err_side;

  assign ctl_err.advance = advance;
  assign ctl_err.valid   = v3;

  cgvf_sqrt #(
    .RAD_W  (RAD1_W),
    .LANES  (2),
    .SIDE_W (SIDE1_W),
    .STEPS  (2)
  ) u_err_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_err),
    .rad       ({rad2_3, rad1_3}),
    .side_in   ({neg1_3, neg2_3, cx3, cy3, cz3, n1x3, n1z3, n2y3, n2z3}),
    .out_valid (v_err),
    .root      (err_root),
    .side_out  (err_side)
  );

  logic               neg1_r, neg2_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic signed [25:0] n1x_r, n2y_r;
  logic signed [27:0] n1z_r;
  logic signed [26:0] n2z_r;

  assign {neg1_r, neg2_r, cx_r, cy_r, cz_r, n1x_r, n1z_r, n2y_r, n2z_r} = err_side;

  // stage 4: gain-weighted roots
  logic signed [SIG_W-1:0]      sig1_c, sig2_c;
  logic signed [SIG_W+24:0]     gp1_c, gp2_c;

  logic               v4;
  logic signed [31:0] g1_4, g2_4, cx4, cy4, cz4;
  logic signed [25:0] n1x4, n2y4;
  logic signed [27:0] n1z4;
  logic signed [26:0] n2z4;

  always_comb begin
    sig1_c = neg1_r ? -$signed({1'b0, err_root[0]}) : $signed({1'b0, err_root[0]});
    sig2_c = neg2_r ? -$signed({1'b0, err_root[1]}) : $signed({1'b0, err_root[1]});
    gp1_c  = $signed({1'b0, gain_first}) * sig1_c;
    gp2_c  = $signed({1'b0, gain_second}) * sig2_c;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      g1_4 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(gp1_c >>> FRAC_BITS));
      g2_4 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(gp2_c >>> FRAC_BITS));
      cx4  <= cx_r;
      cy4  <= cy_r;
      cz4  <= cz_r;
      n1x4 <= n1x_r;
      n2y4 <= n2y_r;
      n1z4 <= n1z_r;
      n2z4 <= n2z_r;
    end
  end

  // stage 5: gain terms along each gradient
  logic signed [57:0] t1_p, t2_p;
  logic signed [59:0] t3_p;
  logic signed [58:0] t4_p;

  logic               v5;
  logic signed [31:0] t1_5, t2_5, t3_5, t4_5, cx5, cy5, cz5;

  always_comb begin
    t1_p = g1_4 * n1x4;
    t2_p = g2_4 * n2y4;
    t3_p = g1_4 * n1z4;
    t4_p = g2_4 * n2z4;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t1_5 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(t1_p >>> FRAC_BITS));
      t2_5 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(t2_p >>> FRAC_BITS));
      t3_5 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(t3_p >>> FRAC_BITS));
      t4_5 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(t4_p >>> FRAC_BITS));
      cx5  <= cx4;
      cy5  <= cy4;
      cz5  <= cz4;
    end
  end

  // stage 6: field vector
  logic               v6;
  logic signed [31:0] vx6, vy6, vz6;

  always_ff @(posedge clk) begin
    if (advance) begin
      vx6 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(cx5) - cgvf_pkg::wide_t'(t1_5));
      vy6 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(cy5) - cgvf_pkg::wide_t'(t2_5));
      vz6 <= cgvf_pkg::sat32(cgvf_pkg::wide_t'(cz5) - cgvf_pkg::wide_t'(t3_5)
                             - cgvf_pkg::wide_t'(t4_5));
    end
  end

  // stage 7: magnitudes and their squares
  logic [31:0] ax_c, ay_c, az_c;

  logic        v7;
  logic [31:0] ax7, ay7, az7;
  logic [63:0] sqx7, sqy7, sqz7;
  logic        negx7, negy7, negz7;

  always_comb begin
    ax_c = vx6[31] ? 32'(-cgvf_pkg::wide_t'(vx6)) : 32'(vx6);
    ay_c = vy6[31] ? 32'(-cgvf_pkg::wide_t'(vy6)) : 32'(vy6);
    az_c = vz6[31] ? 32'(-cgvf_pkg::wide_t'(vz6)) : 32'(vz6);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ax7   <= ax_c;
      ay7   <= ay_c;
      az7   <= az_c;
      sqx7  <= ax_c * ax_c;
      sqy7  <= ay_c * ay_c;
      sqz7  <= az_c * az_c;
      negx7 <= vx6[31];
      negy7 <= vy6[31];
      negz7 <= vz6[31];
    end
  end

  // stage 8: sum of squares, magnitudes times speed, zero detect
  logic                  v8;
  logic [NORM_RAD_W-1:0] sumsq8;
  logic [NUM_W-1:0]      prx8, pry8, prz8;
  logic                  negx8, negy8, negz8, zero8;

  always_ff @(posedge clk) begin
    if (advance) begin
      sumsq8 <= sqx7 + sqy7 + sqz7;
      prx8   <= ax7 * speed;
      pry8   <= ay7 * speed;
      prz8   <= az7 * speed;
      negx8  <= negx7;
      negy8  <= negy7;
      negz8  <= negz7;
      zero8  <= ((ax7 | ay7 | az7) == 32'd0);
    end
  end

  // norm as floor square root of the sum of squares
  cgvf_pkg::stage_ctl_t   ctl_norm;
  logic                   v_norm;
  logic [0:0][NORM_W-1:0] norm_root;
  logic [SIDE2_W-1:0]     norm_side;

  assign ctl_norm.advance = advance;
  assign ctl_norm.valid   = v8;

  cgvf_sqrt #(
    .RAD_W  (NORM_RAD_W),
    .LANES  (1),
    .SIDE_W (SIDE2_W),
    .STEPS  (2)
  ) u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_norm),
    .rad       (sumsq8),
    .side_in   ({negx8, negy8, negz8, zero8, prx8, pry8, prz8}),
    .out_valid (v_norm),
    .root      (norm_root),
    .side_out  (norm_side)
  );

  logic             negx_n, negy_n, negz_n, zero_n;
  logic [NUM_W-1:0] prx_n, pry_n, prz_n;

  assign {negx_n, negy_n, negz_n, zero_n, prx_n, pry_n, prz_n} = norm_side;

  // stage 9: add half the norm for rounding half away from zero
  logic                       v9;
  logic [2:0][NUM_W-1:0]      num9;
  logic [NORM_W-1:0]          norm9;
  logic [SIDE3_W-1:0]         side9;

  always_ff @(posedge clk) begin
    if (advance) begin
      num9[0] <= prx_n + NUM_W'(norm_root[0] >> 1);
      num9[1] <= pry_n + NUM_W'(norm_root[0] >> 1);
      num9[2] <= prz_n + NUM_W'(norm_root[0] >> 1);
      norm9   <= norm_root[0];
      side9   <= {negx_n, negy_n, negz_n, zero_n};
    end
  end

  // quotient never exceeds speed since each magnitude is at most the norm
  cgvf_pkg::stage_ctl_t   ctl_div;
  logic                   v_div;
  logic [2:0][QUO_W-1:0]  quo;
  logic [SIDE3_W-1:0]     div_side;

  assign ctl_div.advance = advance;
  assign ctl_div.valid   = v9;

  cgvf_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (NORM_W),
    .QUO_W  (QUO_W),
    .LANES  (3),
    .SIDE_W (SIDE3_W),
    .STEPS  (2)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_div),
    .num       (num9),
    .den       (norm9),
    .side_in   (side9),
    .out_valid (v_div),
    .quo       (quo),
    .side_out  (div_side)
  );

  // output register: restore signs, zero vector gives zero velocity
  logic signed [cgvf_pkg::VEL_W-1:0] qx_s, qy_s, qz_s;

  always_comb begin
    qx_s = $signed(cgvf_pkg::VEL_W'(quo[0]));
    qy_s = $signed(cgvf_pkg::VEL_W'(quo[1]));
    qz_s = $signed(cgvf_pkg::VEL_W'(quo[2]));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vel_x      <= div_side[0] ? '0 : (div_side[3] ? -qx_s : qx_s);
      vel_y      <= div_side[0] ? '0 : (div_side[2] ? -qy_s : qy_s);
      vel_z      <= div_side[0] ? '0 : (div_side[1] ? -qz_s : qz_s);
      zero_field <= div_side[0];
    end
  end

  // valid bits of the stages outside the units
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      v9        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v_err;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      v9        <= v_norm;
      out_valid <= v_div;
    end
  end

  // checks
  logic signed [cgvf_pkg::VEL_W-1:0] spd_s;
  logic                              vel_in_bound;

  assign spd_s = $signed(cgvf_pkg::VEL_W'(speed));
  assign vel_in_bound = (vel_x <= spd_s) && (vel_x >= -spd_s)
                     && (vel_y <= spd_s) && (vel_y >= -spd_s)
                     && (vel_z <= spd_s) && (vel_z >= -spd_s);

  `CGVF_ASSERT_SAME(a_zero_vel, clk, rst, out_valid && zero_field, vel_x == '0 && vel_y == '0 && vel_z == '0, "zero field with nonzero velocity")
  `CGVF_ASSERT_SAME(a_speed_bound, clk, rst, out_valid && !zero_field, vel_in_bound, "velocity above set speed")
  `CGVF_ASSERT_NEXT(a_accept_enters, clk, rst, in_valid && !in_stall, v1, "accepted beat missing in first stage")
  `CGVF_ASSERT_NEXT(a_hold_first, clk, rst, v1 && !advance, v1, "held beat lost in first stage")

endmodule
